// ===== rtl/dgcd_pkg.sv =====
// Shared types and constants of the directed graph cycle detector.
package dgcd_pkg;

    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_EDGES = 1024;
    localparam int NODE_COUNT_W = 9;
    localparam int LABEL_W = 9;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 9'd256;

    typedef enum logic [1:0] {
        COLOR_UNVISITED = 2'd0,
        COLOR_ON_STACK  = 2'd1,
        COLOR_DONE      = 2'd2
    } t_color;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_RANGE    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_W,
        S_ROOT,
        S_TOP,
        S_EDGE_W,
        S_COLOR_W,
        S_PUSH,
        S_POP_W
    } t_state;

endpackage

// ===== rtl/dgcd_edge_store.sv =====
// Edge store: chain link and target of every loaded edge, one write and one read port.
module dgcd_edge_store #(
    parameter int DEPTH = dgcd_pkg::DEF_MAX_EDGES,
    parameter int AW    = 10,
    parameter int LINKW = 11,
    parameter int NW    = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [LINKW-1:0] i_wr_next,
    input  logic [NW-1:0]    i_wr_target,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [LINKW-1:0] o_rd_next,
    output logic [NW-1:0]    o_rd_target
);

    logic [LINKW-1:0] chain_next  [DEPTH];
    logic [NW-1:0]    edge_target [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            chain_next[i_wr_addr]  <= i_wr_next;
            edge_target[i_wr_addr] <= i_wr_target;
        end
        o_rd_next   <= chain_next[i_rd_addr];
        o_rd_target <= edge_target[i_rd_addr];
    end

endmodule

// ===== rtl/directed_graph_cycle_detector_unit.sv =====
// Top level: edge loading, adjacency chains and the three-colour depth-first walk.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------------------
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (node count)
//  edge     | in        | start / busy               | i_from_node i_to_node i_has_edge i_last
//  verdict  | out       | o_result_valid strobe      | o_possible o_status
//
// Edges load at one per cycle while busy is low; a two-stage head read/write with forwarding
// keeps the rate. After last: a check, per node a scan and colour read, per root a root step,
// per edge a top, edge read and colour read, per push a push, per pop a top and stack read, and
// a top to close, all set by the single read port of each memory; verdict strobe is registered.
// A clearing pass over all MAX_NODES entries runs after reset and after every verdict; busy is high.
// The verdict strobe lasts one cycle and cannot be held off; config is always ready.
module directed_graph_cycle_detector_unit #(
    parameter int MAX_NODES = dgcd_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = dgcd_pkg::DEF_MAX_EDGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dgcd_pkg::NODE_COUNT_W-1:0] i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [dgcd_pkg::LABEL_W-1:0]      i_from_node,
    input  logic [dgcd_pkg::LABEL_W-1:0]      i_to_node,
    input  logic                              i_has_edge,
    input  logic                              i_last,
    output logic                              o_result_valid,
    output logic                              o_possible,
    output logic [1:0]                        o_status
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW  = (NW + 1 > dgcd_pkg::LABEL_W) ? NW + 1 : dgcd_pkg::LABEL_W;
    localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);
    localparam logic [LW-1:0] NODES_L = LW'(MAX_NODES);

    dgcd_pkg::t_state r_state, n_state;

    logic [dgcd_pkg::NODE_COUNT_W-1:0] r_node_count;
    logic [EW-1:0]   r_total;
    logic [1:0]      r_err;
    logic [NW-1:0]   r_clr;
    logic [LW-1:0]   r_s;
    logic [NW:0]     r_depth;
    logic [NW-1:0]   r_top_node;
    logic [EW-1:0]   r_top_cur;
    logic [NW-1:0]   r_v;
    logic            r_out_valid;
    logic            r_possible;
    logic [1:0]      r_status;

    // load pipeline
    logic            r_ld_valid;
    logic [NW-1:0]   r_ld_node;
    logic [NW-1:0]   r_ld_tgt;
    logic [EW-1:0]   r_ld_idx;
    logic            r_fwd_hit;
    logic [EW-1:0]   r_fwd_val;

    // memories
    logic [EW-1:0]   chain_head [MAX_NODES];
    logic [1:0]      node_color [MAX_NODES];
    logic [NW-1:0]   stack_node [MAX_NODES];
    logic [EW-1:0]   stack_cur  [MAX_NODES];
    logic [EW-1:0]   r_head_q;
    logic [1:0]      r_color_q;
    logic [NW-1:0]   r_stk_node_q;
    logic [EW-1:0]   r_stk_cur_q;

    logic [EW-1:0]   es_next;
    logic [NW-1:0]   es_target;

    logic            accept;
    logic [LW-1:0]   eff_n;
    logic [LW-1:0]   from_l;
    logic [LW-1:0]   to_l;
    logic            bad_label;
    logic            full;
    logic            load_ok;
    logic [NW-1:0]   from_idx;
    logic [NW-1:0]   to_idx;
    logic [EW-1:0]   old_head;

    logic            head_we;
    logic [NW-1:0]   head_waddr;
    logic [EW-1:0]   head_wdata;
    logic [NW-1:0]   head_raddr;
    logic            color_we;
    logic [NW-1:0]   color_waddr;
    logic [1:0]      color_wdata;
    logic [NW-1:0]   color_raddr;
    logic            stk_we;
    logic [NW-1:0]   stk_raddr;
    logic [NW-1:0]   stk_waddr;
    logic            emit;
    logic            emit_possible;

    assign o_cfg_ready    = 1'b1;
    assign busy           = (r_state != dgcd_pkg::S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_possible     = r_possible;
    assign o_status       = r_status;

    assign accept    = start && !busy;
    assign eff_n     = (LW'(r_node_count) > NODES_L) ? NODES_L : LW'(r_node_count);
    assign from_l    = LW'(i_from_node);
    assign to_l      = LW'(i_to_node);
    assign bad_label = (from_l == '0) || (from_l > eff_n) || (to_l == '0) || (to_l > eff_n);
    assign full      = (r_total == EMPTY);
    assign load_ok   = accept && i_has_edge && !bad_label && !full;
    assign from_idx  = NW'(from_l - LW'(1));
    assign to_idx    = NW'(to_l - LW'(1));
    assign old_head  = r_fwd_hit ? r_fwd_val : r_head_q;
    assign stk_waddr = NW'(r_depth - (NW+1)'(1));
    assign stk_raddr = NW'(r_depth - (NW+1)'(2));

    // next state and memory controls
    always_comb begin
        n_state       = r_state;
        head_we       = 1'b0;
        head_waddr    = r_ld_node;
        head_wdata    = r_ld_idx;
        head_raddr    = from_idx;
        color_we      = 1'b0;
        color_waddr   = r_clr;
        color_wdata   = dgcd_pkg::COLOR_UNVISITED;
        color_raddr   = r_s[NW-1:0];
        stk_we        = 1'b0;
        emit          = 1'b0;
        emit_possible = 1'b0;

        if (r_ld_valid) begin
            head_we = 1'b1;
        end

        unique case (r_state)
            dgcd_pkg::S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = EMPTY;
                color_we   = 1'b1;
                if (r_clr == NW'(MAX_NODES - 1)) begin
                    n_state = dgcd_pkg::S_IDLE;
                end
            end
            dgcd_pkg::S_IDLE: begin
                if (accept && i_last) begin
                    n_state = dgcd_pkg::S_CHECK;
                end
            end
            dgcd_pkg::S_CHECK: begin
                if (r_err != dgcd_pkg::STATUS_OK) begin
                    emit    = 1'b1;
                    n_state = dgcd_pkg::S_CLEAR;
                end else begin
                    n_state = dgcd_pkg::S_SCAN;
                end
            end
            dgcd_pkg::S_SCAN: begin
                if (r_s >= eff_n) begin
                    emit          = 1'b1;
                    emit_possible = 1'b1;
                    n_state       = dgcd_pkg::S_CLEAR;
                end else begin
                    n_state = dgcd_pkg::S_SCAN_W;
                end
            end
            dgcd_pkg::S_SCAN_W: begin
                head_raddr = r_s[NW-1:0];
                if (r_color_q == dgcd_pkg::COLOR_UNVISITED) begin
                    color_we    = 1'b1;
                    color_waddr = r_s[NW-1:0];
                    color_wdata = dgcd_pkg::COLOR_ON_STACK;
                    n_state     = dgcd_pkg::S_ROOT;
                end else begin
                    n_state = dgcd_pkg::S_SCAN;
                end
            end
            dgcd_pkg::S_ROOT: begin
                n_state = dgcd_pkg::S_TOP;
            end
            dgcd_pkg::S_TOP: begin
                if (r_depth == '0) begin
                    n_state = dgcd_pkg::S_SCAN;
                end else if (r_top_cur >= EMPTY) begin
                    color_we    = 1'b1;
                    color_waddr = r_top_node;
                    color_wdata = dgcd_pkg::COLOR_DONE;
                    n_state     = (r_depth > (NW+1)'(1)) ? dgcd_pkg::S_POP_W : dgcd_pkg::S_TOP;
                end else begin
                    n_state = dgcd_pkg::S_EDGE_W;
                end
            end
            dgcd_pkg::S_EDGE_W: begin
                color_raddr = es_target;
                n_state     = dgcd_pkg::S_COLOR_W;
            end
            dgcd_pkg::S_COLOR_W: begin
                head_raddr = r_v;
                if (r_color_q == dgcd_pkg::COLOR_ON_STACK) begin
                    emit    = 1'b1;
                    n_state = dgcd_pkg::S_CLEAR;
                end else if (r_color_q == dgcd_pkg::COLOR_UNVISITED &&
                             r_depth < (NW+1)'(MAX_NODES)) begin
                    color_we    = 1'b1;
                    color_waddr = r_v;
                    color_wdata = dgcd_pkg::COLOR_ON_STACK;
                    n_state     = dgcd_pkg::S_PUSH;
                end else begin
                    n_state = dgcd_pkg::S_TOP;
                end
            end
            dgcd_pkg::S_PUSH: begin
                stk_we  = 1'b1;
                n_state = dgcd_pkg::S_TOP;
            end
            dgcd_pkg::S_POP_W: begin
                n_state = dgcd_pkg::S_TOP;
            end
            default: begin
                n_state = dgcd_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgcd_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            chain_head[head_waddr] <= head_wdata;
        end
        r_head_q <= chain_head[head_raddr];
        if (color_we) begin
            node_color[color_waddr] <= color_wdata;
        end
        r_color_q <= node_color[color_raddr];
        if (stk_we) begin
            stack_node[stk_waddr] <= r_top_node;
            stack_cur[stk_waddr]  <= r_top_cur;
        end
        r_stk_node_q <= stack_node[stk_raddr];
        r_stk_cur_q  <= stack_cur[stk_raddr];
    end

    dgcd_edge_store #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW),
        .LINKW (EW),
        .NW    (NW)
    ) u_edge_store (
        .i_clk       (i_clk),
        .i_wr_en     (r_ld_valid),
        .i_wr_addr   (r_ld_idx[EAW-1:0]),
        .i_wr_next   (old_head),
        .i_wr_target (r_ld_tgt),
        .i_rd_addr   (r_top_cur[EAW-1:0]),
        .o_rd_next   (es_next),
        .o_rd_target (es_target)
    );

    // control and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dgcd_pkg::NODE_COUNT_RST;
            r_total      <= '0;
            r_err        <= dgcd_pkg::STATUS_OK;
            r_clr        <= '0;
            r_s          <= '0;
            r_depth      <= '0;
            r_ld_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            r_out_valid <= emit;
            r_ld_valid  <= load_ok;
            r_fwd_hit   <= load_ok && r_ld_valid && (r_ld_node == from_idx);

            if (accept && i_has_edge && r_err == dgcd_pkg::STATUS_OK) begin
                if (bad_label) begin
                    r_err <= dgcd_pkg::STATUS_RANGE;
                end else if (full) begin
                    r_err <= dgcd_pkg::STATUS_OVERFLOW;
                end
            end
            if (load_ok) begin
                r_total <= r_total + EW'(1);
            end

            unique case (r_state)
                dgcd_pkg::S_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                end
                dgcd_pkg::S_CHECK: begin
                    r_s <= '0;
                end
                dgcd_pkg::S_SCAN_W: begin
                    if (r_color_q != dgcd_pkg::COLOR_UNVISITED) begin
                        r_s <= r_s + LW'(1);
                    end
                end
                dgcd_pkg::S_ROOT: begin
                    r_depth <= (NW+1)'(1);
                end
                dgcd_pkg::S_TOP: begin
                    if (r_depth == '0) begin
                        r_s <= r_s + LW'(1);
                    end else if (r_top_cur >= EMPTY) begin
                        r_depth <= r_depth - (NW+1)'(1);
                    end
                end
                dgcd_pkg::S_PUSH: begin
                    r_depth <= r_depth + (NW+1)'(1);
                end
                default: begin
                end
            endcase

            // a verdict resets edge count, error and walk depth and restarts the clear; node count is kept
            if (emit) begin
                r_total <= '0;
                r_err   <= dgcd_pkg::STATUS_OK;
                r_clr   <= '0;
                r_depth <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_ld_node <= from_idx;
            r_ld_tgt  <= to_idx;
            r_ld_idx  <= r_total;
            r_fwd_val <= r_ld_idx;
        end
        if (emit) begin
            r_possible <= emit_possible;
            r_status   <= r_err;
        end
        case (r_state)
            dgcd_pkg::S_ROOT: begin
                r_top_node <= r_s[NW-1:0];
                r_top_cur  <= r_head_q;
            end
            dgcd_pkg::S_EDGE_W: begin
                r_top_cur <= es_next;
                r_v       <= es_target;
            end
            dgcd_pkg::S_PUSH: begin
                r_top_node <= r_v;
                r_top_cur  <= r_head_q;
            end
            dgcd_pkg::S_POP_W: begin
                r_top_node <= r_stk_node_q;
                r_top_cur  <= r_stk_cur_q;
            end
            default: begin
            end
        endcase
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> busy)
        else $error("verdict strobe outside a busy period");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("verdict strobe longer than one cycle");

    a_error_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != dgcd_pkg::STATUS_OK) |-> !r_possible)
        else $error("error status with a positive verdict");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= (NW+1)'(MAX_NODES))
        else $error("walk stack beyond capacity");

    a_no_load_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dgcd_pkg::S_SCAN_W || r_state == dgcd_pkg::S_COLOR_W) |-> !r_ld_valid)
        else $error("edge load overlaps a walk head read");

endmodule
